>>> rtl/ialu_pkg.sv
package ialu_pkg;

    localparam int unsigned WORD_BITS_DEF = 32;
    localparam int unsigned KIND_W        = 4;
    localparam int unsigned RESULT_W      = 32;

    localparam logic [KIND_W-1:0] OP_AND = 4'd0;
    localparam logic [KIND_W-1:0] OP_OR  = 4'd1;
    localparam logic [KIND_W-1:0] OP_XOR = 4'd2;
    localparam logic [KIND_W-1:0] OP_NOT = 4'd3;
    localparam logic [KIND_W-1:0] OP_ADD = 4'd4;
    localparam logic [KIND_W-1:0] OP_SUB = 4'd5;
    localparam logic [KIND_W-1:0] OP_MUL = 4'd6;
    localparam logic [KIND_W-1:0] OP_DIV = 4'd7;
    localparam logic [KIND_W-1:0] OP_MOD = 4'd8;
    localparam logic [KIND_W-1:0] OP_SHL = 4'd9;
    localparam logic [KIND_W-1:0] OP_SHR = 4'd10;

    // control that travels alongside the data through every cell
    typedef struct packed {
        logic              vld;
        logic [KIND_W-1:0] kind;
    } ctl_t;

endpackage

>>> rtl/ialu_cell.sv
// One step of the chain: one restoring-division bit and one shift-and-add
// partial product, then registers everything for the next cell.
module ialu_cell #(
    parameter int unsigned W   = ialu_pkg::WORD_BITS_DEF,
    parameter int unsigned IDX = 0
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  ialu_pkg::ctl_t ctl_in,
    input  logic [W-1:0]   a_in,
    input  logic [W-1:0]   b_in,
    input  logic [W-1:0]   quo_in,
    input  logic [W-1:0]   rem_in,
    input  logic [W-1:0]   prod_in,
    input  logic [W-1:0]   early_in,
    output ialu_pkg::ctl_t ctl_out,
    output logic [W-1:0]   a_out,
    output logic [W-1:0]   b_out,
    output logic [W-1:0]   quo_out,
    output logic [W-1:0]   rem_out,
    output logic [W-1:0]   prod_out,
    output logic [W-1:0]   early_out
);

    localparam int unsigned BIT = W - 1 - IDX;

    ialu_pkg::ctl_t ctl_reg;
    logic [W-1:0]   a_reg, b_reg, quo_reg, rem_reg, prod_reg, early_reg;
    logic [W:0]     trial;
    logic [W:0]     diff;
    logic [W-1:0]   rem_next, quo_next, prod_next;

    always_comb
    begin
        // remainder shifted left with the next dividend bit (MSB first)
        trial    = {rem_in, a_in[BIT]};
        diff     = trial - {1'b0, b_in};
        quo_next = quo_in;
        if (!diff[W])
        begin
            rem_next      = diff[W-1:0];
            quo_next[BIT] = 1'b1;
        end
        else
        begin
            rem_next = trial[W-1:0];
        end
        // product: add A shifted by this bit position when B has it set
        prod_next = prod_in + (b_in[IDX] ? (a_in << IDX) : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg     <= a_in;
            b_reg     <= b_in;
            quo_reg   <= quo_next;
            rem_reg   <= rem_next;
            prod_reg  <= prod_next;
            early_reg <= early_in;
        end
    end

    assign ctl_out   = ctl_reg;
    assign a_out     = a_reg;
    assign b_out     = b_reg;
    assign quo_out   = quo_reg;
    assign rem_out   = rem_reg;
    assign prod_out  = prod_reg;
    assign early_out = early_reg;

endmodule

>>> rtl/int32_alu_with_mul_div_top.sv
// Pipelined integer ALU: AND, OR, XOR, NOT A, wrapping add/sub, low word of
// the product, unsigned quotient and remainder, and logical shifts by B
// (a count of WORD_BITS or more gives zero). Division by zero gives all
// ones for the quotient and A for the remainder; codes 11 to 15 give zero.
// A request passes a chain of WORD_BITS cells, each settling one quotient
// bit and one partial product, and then the output register; one request
// is accepted every cycle unless the chain stalls. The chain stalls as a
// whole while the output register is full and not taken; ready is then low.
module int32_alu_with_mul_div_top #(
    parameter int unsigned WORD_BITS = ialu_pkg::WORD_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [ialu_pkg::KIND_W-1:0]    kind,
    input  logic [ialu_pkg::RESULT_W-1:0]  operand_a,
    input  logic [ialu_pkg::RESULT_W-1:0]  operand_b,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [ialu_pkg::RESULT_W-1:0]  result
);

    localparam int unsigned W  = WORD_BITS;
    localparam int unsigned RW = ialu_pkg::RESULT_W;
    localparam int unsigned CW = $clog2(W + 1);

    ialu_pkg::ctl_t ctl_c [0:W];
    logic [W-1:0]   a_c [0:W];
    logic [W-1:0]   b_c [0:W];
    logic [W-1:0]   q_c [0:W];
    logic [W-1:0]   r_c [0:W];
    logic [W-1:0]   p_c [0:W];
    logic [W-1:0]   e_c [0:W];

    logic           adv;
    logic           out_valid_reg;
    logic [RW-1:0]  result_reg;
    logic [W-1:0]   a_in, b_in, early, fin;
    logic           big_shift;
    logic [CW-1:0]  sh;

    // chain advances unless the output register holds an untaken result
    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    // operands at word width: truncate or zero-extend
    always_comb
    begin
        a_in = W'(operand_a);
        b_in = W'(operand_b);
    end

    // logic, add/sub and shift ops worked out on entry, carried along the chain
    always_comb
    begin
        big_shift = (b_in >= W'(W));
        sh        = b_in[CW-1:0];
        unique case (kind)
            ialu_pkg::OP_AND: early = a_in & b_in;
            ialu_pkg::OP_OR:  early = a_in | b_in;
            ialu_pkg::OP_XOR: early = a_in ^ b_in;
            ialu_pkg::OP_NOT: early = ~a_in;
            ialu_pkg::OP_ADD: early = a_in + b_in;
            ialu_pkg::OP_SUB: early = a_in - b_in;
            ialu_pkg::OP_SHL: early = big_shift ? '0 : (a_in << sh);
            ialu_pkg::OP_SHR: early = big_shift ? '0 : (a_in >> sh);
            default:          early = '0;
        endcase
    end

    assign ctl_c[0].vld  = in_valid;
    assign ctl_c[0].kind = kind;
    assign a_c[0] = a_in;
    assign b_c[0] = b_in;
    assign q_c[0] = '0;
    assign r_c[0] = '0;
    assign p_c[0] = '0;
    assign e_c[0] = early;

    for (genvar i = 0; i < W; i++)
    begin : g_cell
        ialu_cell #(.W(W), .IDX(i)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (adv),
            .ctl_in   (ctl_c[i]),
            .a_in     (a_c[i]),
            .b_in     (b_c[i]),
            .quo_in   (q_c[i]),
            .rem_in   (r_c[i]),
            .prod_in  (p_c[i]),
            .early_in (e_c[i]),
            .ctl_out  (ctl_c[i+1]),
            .a_out    (a_c[i+1]),
            .b_out    (b_c[i+1]),
            .quo_out  (q_c[i+1]),
            .rem_out  (r_c[i+1]),
            .prod_out (p_c[i+1]),
            .early_out(e_c[i+1])
        );
    end

    // restoring division already yields all ones / A for a zero divisor
    always_comb
    begin
        unique case (ctl_c[W].kind)
            ialu_pkg::OP_MUL: fin = p_c[W];
            ialu_pkg::OP_DIV: fin = q_c[W];
            ialu_pkg::OP_MOD: fin = r_c[W];
            default:          fin = e_c[W];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= ctl_c[W].vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            result_reg <= RW'(fin);
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    // a stalled result must hold
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result))
        else $error("result changed while stalled");

    // ready follows the output register
    a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("ready mismatch");

    // an accepted request is captured in the register of the first cell when
    // nothing stalls
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && out_ready |=> ctl_c[1].vld)
        else $error("request lost in first cell");

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned N_RANDOM   = 1450;
    localparam int unsigned LATENCY    = 33;
    localparam int unsigned CYCLE_CAP  = 200000;
    localparam int unsigned SHOW_LIMIT = 10;

    // one pending request for the driver
    typedef struct {
        logic [ialu_pkg::KIND_W-1:0]   kind;
        logic [ialu_pkg::RESULT_W-1:0] a;
        logic [ialu_pkg::RESULT_W-1:0] b;
    } alu_req_t;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    logic [ialu_pkg::KIND_W-1:0]   kind;
    logic [ialu_pkg::RESULT_W-1:0] operand_a;
    logic [ialu_pkg::RESULT_W-1:0] operand_b;
    logic                          out_valid;
    logic                          out_ready;
    logic [ialu_pkg::RESULT_W-1:0] result;

    alu_req_t                      req_q[$];
    logic [ialu_pkg::RESULT_W-1:0] want_q[$];

    int unsigned n_sent;
    int unsigned n_seen;
    int unsigned n_bad;
    int unsigned n_cycles;
    int unsigned op_hits[16];
    int unsigned burst_left;
    int unsigned gap_left;
    int unsigned stall_phase;
    bit          stim_done;

    int32_alu_with_mul_div_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (result)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Golden ALU: unsigned 32-bit, wrapping; divide by zero gives all ones
    // for the quotient and A for the remainder; unused codes give zero.
    function automatic logic [ialu_pkg::RESULT_W-1:0] alu_value(
        input logic [ialu_pkg::KIND_W-1:0]   op,
        input logic [ialu_pkg::RESULT_W-1:0] a,
        input logic [ialu_pkg::RESULT_W-1:0] b);
        logic [63:0] prod;
        begin
            prod = 64'(a) * 64'(b);
            case (op)
                ialu_pkg::OP_AND: return a & b;
                ialu_pkg::OP_OR:  return a | b;
                ialu_pkg::OP_XOR: return a ^ b;
                ialu_pkg::OP_NOT: return ~a;
                ialu_pkg::OP_ADD: return a + b;
                ialu_pkg::OP_SUB: return a - b;
                ialu_pkg::OP_MUL: return prod[ialu_pkg::RESULT_W-1:0];
                ialu_pkg::OP_DIV: return (b == '0) ? '1 : a / b;
                ialu_pkg::OP_MOD: return (b == '0) ? a : a % b;
                ialu_pkg::OP_SHL: return (b >= ialu_pkg::RESULT_W) ? '0 : a << b[5:0];
                ialu_pkg::OP_SHR: return (b >= ialu_pkg::RESULT_W) ? '0 : a >> b[5:0];
                default:          return '0;
            endcase
        end
    endfunction

    function automatic logic [ialu_pkg::RESULT_W-1:0] pick_operand();
        logic [ialu_pkg::RESULT_W-1:0] v;
        begin
            case ($urandom_range(0, 9))
                0:       v = '0;
                1:       v = '1;
                2:       v = 32'h8000_0000;
                3:       v = $urandom_range(0, 40);
                4:       v = $urandom_range(0, 255);
                5:       v = 32'(1) << $urandom_range(0, 31);
                default: v = $urandom();
            endcase
            return v;
        end
    endfunction

    task automatic add_req(input logic [ialu_pkg::KIND_W-1:0] op,
                           input logic [ialu_pkg::RESULT_W-1:0] a,
                           input logic [ialu_pkg::RESULT_W-1:0] b);
        alu_req_t r;
        begin
            r.kind = op;
            r.a    = a;
            r.b    = b;
            req_q.push_back(r);
        end
    endtask

    // stimulus: directed corners first, then random requests
    initial
    begin
        logic [ialu_pkg::KIND_W-1:0] op;
        add_req(ialu_pkg::OP_AND, '1, 32'hA5A5_5A5A);
        add_req(ialu_pkg::OP_OR,  '0, 32'h8000_0001);
        add_req(ialu_pkg::OP_XOR, '1, '1);
        add_req(ialu_pkg::OP_NOT, 32'h0F0F_0F0F, '1);  // B ignored
        add_req(ialu_pkg::OP_ADD, '1, 32'd1);          // wraps to zero
        add_req(ialu_pkg::OP_SUB, '0, 32'd1);          // wraps to all ones
        add_req(ialu_pkg::OP_MUL, '1, '1);
        add_req(ialu_pkg::OP_MUL, 32'h0001_0000, 32'h0001_0000);
        add_req(ialu_pkg::OP_DIV, 32'd1234, '0);       // divide by zero
        add_req(ialu_pkg::OP_MOD, 32'd1234, '0);
        add_req(ialu_pkg::OP_DIV, '1, 32'd1);
        add_req(ialu_pkg::OP_MOD, '1, 32'd7);
        add_req(ialu_pkg::OP_DIV, 32'd5, 32'd9);
        add_req(ialu_pkg::OP_SHL, '1, 32'd31);
        add_req(ialu_pkg::OP_SHL, '1, 32'd32);         // count too large
        add_req(ialu_pkg::OP_SHR, '1, 32'd31);
        add_req(ialu_pkg::OP_SHR, '1, '1);
        add_req(ialu_pkg::OP_SHL, 32'd1, '0);
        add_req(4'd11, '1, '1);                        // unused codes
        add_req(4'd15, '1, '1);
        for (int i = 0; i < N_RANDOM; i++)
        begin
            op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(11, 15))
                                              : 4'($urandom_range(0, 10));
            if (op == ialu_pkg::OP_SHL || op == ialu_pkg::OP_SHR)
                add_req(op, pick_operand(), ($urandom_range(0, 3) == 0) ? pick_operand()
                                                                       : $urandom_range(0, 40));
            else
                add_req(op, pick_operand(), pick_operand());
        end
        stim_done = 1'b1;
    end

    // driver: random-length bursts; after the first request of each burst an idle gap of random length, possibly zero
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            kind       <= '0;
            operand_a  <= '0;
            operand_b  <= '0;
            burst_left <= 0;
            gap_left   <= 0;
            n_sent     <= 0;
        end
        else
        begin
            bit take;
            bit busy;
            take = in_valid && in_ready;
            busy = in_valid && !in_ready;
            if (take)
            begin
                want_q.push_back(alu_value(kind, operand_a, operand_b));
                op_hits[kind] <= op_hits[kind] + 1;
                n_sent <= n_sent + 1;
            end
            if (!busy)
            begin
                if (gap_left != 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (req_q.size() != 0)
                begin
                    alu_req_t r;
                    r = req_q.pop_front();
                    in_valid  <= 1'b1;
                    kind      <= r.kind;
                    operand_a <= r.a;
                    operand_b <= r.b;
                    if (burst_left == 0)
                    begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver back-pressure: phases of free flow, steady stall mix, heavy stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready   <= 1'b0;
            stall_phase <= 0;
        end
        else
        begin
            stall_phase <= stall_phase + 1;
            case ((stall_phase / 300) % 3)
                0:       out_ready <= 1'b1;
                1:       out_ready <= ($urandom_range(0, 3) != 0);
                default: out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // monitor: compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (want_q.size() == 0)
            begin
                n_bad <= n_bad + 1;
                if (n_bad < SHOW_LIMIT)
                    $display("unexpected result %h with nothing outstanding", result);
            end
            else
            begin
                logic [ialu_pkg::RESULT_W-1:0] want;
                want = want_q.pop_front();
                if (result !== want)
                begin
                    n_bad <= n_bad + 1;
                    if (n_bad < SHOW_LIMIT)
                        $display("result mismatch: expected %h, got %h", want, result);
                end
            end
            n_seen <= n_seen + 1;
        end
    end

    always @(posedge clk)
    begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_CAP)
        begin
            $display("timeout after %0d cycles", n_cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        wait (stim_done);
        while (req_q.size() != 0 || in_valid || want_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
        $display("%0d requests sent, %0d results checked, %0d mismatches, %0d outstanding",
                 n_sent, n_seen, n_bad, want_q.size());
        $display("all eleven operations plus unused codes, divide by zero and long shifts");
        if (n_bad == 0 && want_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> sim.f
rtl/ialu_pkg.sv
rtl/ialu_cell.sv
rtl/int32_alu_with_mul_div_top.sv
verif/tb_top.sv
